/* hw/rtl/overlap_blend_rel_norm_unit_macros.svh */
// Assertion macros used by the overlap blend and norm datapath.
`ifndef OVERLAP_BLEND_REL_NORM_UNIT_MACROS_SVH
`define OVERLAP_BLEND_REL_NORM_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define OBRN_ASSERT_IMPL(lbl, ck, rstn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("obrn assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define OBRN_ASSERT_NEXT(lbl, ck, rstn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("obrn assertion failed");

`endif

/* hw/rtl/obrn_pkg.sv */
// Package with types, constants and codes of the overlap blend and norm unit.
package obrn_pkg;

    localparam int OVERLAP_MAX_DEF = 256;
    localparam int VALUE_WIDTH_DEF = 32;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 9;
    localparam int OW_W       = 9;

    localparam logic [CFG_IDX_W-1:0] REG_OVERLAP_WIDTH    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SMOOTHING_ENABLE = 8'd1;

    localparam logic [OW_W-1:0] OW_RESET = 9'd2;
    localparam logic            EN_RESET = 1'b1;

    localparam int FRAC_W    = 16;
    localparam int SUM_W     = 64;
    localparam int NORM_W    = 32;
    localparam int DVD_W     = 96;
    localparam int DIV_CNT_W = 7;
    localparam int SQRT_STEPS = 32;
    localparam int SQRT_CNT_W = 5;

    typedef enum logic [3:0] {
        S_IDLE,
        S_WDIV_GO,
        S_WDIV_WAIT,
        S_MUL,
        S_BLEND,
        S_SQ_CHG,
        S_SQ_VAL,
        S_ACC,
        S_CHECK,
        S_NDIV_GO,
        S_NDIV_WAIT,
        S_SQRT,
        S_DONE
    } state_t;

    typedef struct packed {
        logic capture;
        logic wdiv_start;
        logic ndiv_start;
        logic mul;
        logic blend;
        logic sq_chg;
        logic sq_val;
        logic accum;
        logic sqrt_init;
        logic sqrt_step;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic enable;
        logic last;
        logic div_busy;
        logic value_zero;
        logic norm_ovf;
        logic out_free;
    } sts_t;

endpackage

/* hw/rtl/obrn_if.sv */
// Handshake interfaces for the input, result and configuration channels.
interface obrn_in_if #(parameter int VALUE_WIDTH = obrn_pkg::VALUE_WIDTH_DEF);
    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] sub_value;
    logic signed [VALUE_WIDTH-1:0] nbr_value;
    logic                          last_element;

    modport source (output valid, sub_value, nbr_value, last_element, input ready);
    modport sink   (input valid, sub_value, nbr_value, last_element, output ready);
endinterface

interface obrn_out_if #(parameter int VALUE_WIDTH = obrn_pkg::VALUE_WIDTH_DEF);
    logic                            valid;
    logic                            ready;
    logic signed [VALUE_WIDTH-1:0]   blend_value;
    logic                            norm_valid;
    logic [obrn_pkg::NORM_W-1:0]     rel_norm;
    logic                            zero_divide;

    modport source (output valid, blend_value, norm_valid, rel_norm, zero_divide, input ready);
    modport sink   (input valid, blend_value, norm_valid, rel_norm, zero_divide, output ready);
endinterface

interface obrn_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [obrn_pkg::CFG_IDX_W-1:0]  index;
    logic [obrn_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* hw/rtl/obrn_div.sv */
// Shared restoring divider, one quotient bit per cycle.
module obrn_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [obrn_pkg::DVD_W-1:0]  dividend,
    input  logic [obrn_pkg::SUM_W-1:0]  divisor,
    input  logic [obrn_pkg::DIV_CNT_W-1:0] iters,
    output logic                        busy,
    output logic [obrn_pkg::SUM_W-1:0]  quot
);
    import obrn_pkg::*;

    logic                 busy_reg, busy_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DVD_W-1:0]     dvd_reg, dvd_next;
    logic [SUM_W-1:0]     den_reg, den_next;
    logic [SUM_W:0]       rem_reg, rem_next;
    logic [SUM_W-1:0]     q_reg, q_next;
    logic [SUM_W:0]       rem_sh;
    logic                 ge;

    assign rem_sh = {rem_reg[SUM_W-1:0], dvd_reg[DVD_W-1]};
    assign ge     = rem_sh >= {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = iters;
            dvd_next  = dividend;
            den_next  = divisor;
            rem_next  = '0;
            q_next    = '0;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[DVD_W-2:0], 1'b0};
            rem_next = ge ? (rem_sh - {1'b0, den_reg}) : rem_sh;
            q_next   = {q_reg[SUM_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
    end

    assign busy = busy_reg;
    assign quot = q_reg;

endmodule

/* hw/rtl/obrn_dp.sv */
// Datapath: configuration, column tracking, blend, squares, sums, norm and result register.
`include "overlap_blend_rel_norm_unit_macros.svh"

module obrn_dp #(
    parameter int OVERLAP_MAX = obrn_pkg::OVERLAP_MAX_DEF,
    parameter int VALUE_WIDTH = obrn_pkg::VALUE_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [obrn_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [obrn_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic signed [VALUE_WIDTH-1:0]     in_cur,
    input  logic signed [VALUE_WIDTH-1:0]     in_ghost,
    input  logic                              in_last,
    input  obrn_pkg::cmd_t                    cmd,
    output obrn_pkg::sts_t                    sts,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [VALUE_WIDTH-1:0]     out_new_value,
    output logic                              out_norm_valid,
    output logic [obrn_pkg::NORM_W-1:0]       out_rel_norm,
    output logic                              out_zero_divide
);
    import obrn_pkg::*;

    localparam int CW   = $clog2(OVERLAP_MAX);
    localparam int WCMP = (CW + 1 > OW_W) ? CW + 1 : OW_W;
    localparam int NW   = CW + FRAC_W;
    localparam int PW   = VALUE_WIDTH + FRAC_W + 2;
    localparam int TW   = PW + 1;
    localparam logic signed [FRAC_W+1:0] ONE   = 18'sd65536;
    localparam logic signed [TW-1:0]     ROUND = TW'(32768);

    logic [OW_W-1:0]   ow_reg;
    logic              en_reg;
    logic [CW-1:0]     col_reg;
    logic [WCMP-1:0]   ow_ext, w_eff, col_ext, col_use, col_inc, col_nx, w_diff;

    logic signed [VALUE_WIDTH-1:0] cur_reg, ghost_reg, nv_reg;
    logic                          last_reg;
    logic [NW-1:0]                 wnum_reg;
    logic [CW-1:0]                 wden_reg;

    logic                 div_start, div_busy;
    logic [DVD_W-1:0]     div_dvd;
    logic [SUM_W-1:0]     div_den, div_q;
    logic [DIV_CNT_W-1:0] div_iters;

    logic signed [FRAC_W+1:0] wt_s, wc_s;
    logic signed [PW-1:0]     pa_reg, pb_reg;
    logic signed [TW-1:0]     t_sum;

    logic signed [VALUE_WIDTH:0] chg;
    logic [VALUE_WIDTH:0]        mag_chg, mag_nv;
    logic [SUM_W-1:0]            sq_op, sq_reg;
    logic [SUM_W-1:0]            change_sum_reg, value_sum_reg;

    logic [SUM_W-1:0]  rad_reg;
    logic [35:0]       srem_reg, srem_sh, strial;
    logic [NORM_W-1:0] root_reg;

    logic                          out_valid_reg;
    logic signed [VALUE_WIDTH-1:0] onv_reg;
    logic                          olast_reg, ozd_reg;
    logic [NORM_W-1:0]             onorm_reg;
    logic                          value_zero, norm_ovf;

    function automatic logic [SUM_W-1:0] sq_sat(input logic [SUM_W-1:0] m);
        logic [SUM_W-1:0] r;
        if (|m[SUM_W-1:32])
        begin
            r = '1;
        end
        else
        begin
            r = SUM_W'(m[31:0]) * SUM_W'(m[31:0]);
        end
        return r;
    endfunction

    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                                 input logic [SUM_W-1:0] b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[SUM_W] ? '1 : s[SUM_W-1:0];
    endfunction

    // Effective width and column of the word being captured.
    always_comb
    begin
        ow_ext = WCMP'(ow_reg);
        if (ow_ext < WCMP'(2))
        begin
            w_eff = WCMP'(2);
        end
        else if (ow_ext > WCMP'(OVERLAP_MAX))
        begin
            w_eff = WCMP'(OVERLAP_MAX);
        end
        else
        begin
            w_eff = ow_ext;
        end
        col_ext = WCMP'(col_reg);
        col_use = (col_ext >= w_eff) ? '0 : col_ext;
        col_inc = col_use + 1'b1;
        col_nx  = (in_last || col_inc >= w_eff) ? '0 : col_inc;
        w_diff  = w_eff - 1'b1 - col_use;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ow_reg  <= OW_RESET;
            en_reg  <= EN_RESET;
            col_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_OVERLAP_WIDTH:    ow_reg <= cfg_data[OW_W-1:0];
                    REG_SMOOTHING_ENABLE: en_reg <= cfg_data[0];
                    default:              ;
                endcase
            end
            if (cmd.capture)
            begin
                col_reg <= col_nx[CW-1:0];
            end
        end
    end

    // Weight divider and norm divider share one unit.
    assign div_start = cmd.wdiv_start || cmd.ndiv_start;
    assign div_dvd   = cmd.ndiv_start ? {change_sum_reg, 32'b0} : {wnum_reg, (DVD_W-NW)'(0)};
    assign div_den   = cmd.ndiv_start ? value_sum_reg : SUM_W'(wden_reg);
    assign div_iters = cmd.ndiv_start ? DIV_CNT_W'(DVD_W) : DIV_CNT_W'(NW);

    obrn_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_den),
        .iters    (div_iters),
        .busy     (div_busy),
        .quot     (div_q)
    );

    assign wt_s  = {1'b0, div_q[FRAC_W:0]};
    assign wc_s  = ONE - wt_s;
    assign t_sum = TW'(pa_reg) + TW'(pb_reg) + ROUND;

    assign chg     = (VALUE_WIDTH+1)'(nv_reg) - (VALUE_WIDTH+1)'(cur_reg);
    assign mag_chg = chg[VALUE_WIDTH] ? (VALUE_WIDTH+1)'(-chg) : (VALUE_WIDTH+1)'(chg);
    assign mag_nv  = nv_reg[VALUE_WIDTH-1] ? (VALUE_WIDTH+1)'(-(VALUE_WIDTH+1)'(nv_reg))
                                           : (VALUE_WIDTH+1)'(nv_reg);
    assign sq_op   = cmd.sq_val ? SUM_W'(mag_nv) : SUM_W'(mag_chg);

    assign srem_sh = {srem_reg[33:0], rad_reg[SUM_W-1:SUM_W-2]};
    assign strial  = {2'b0, root_reg, 2'b01};

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cur_reg   <= in_cur;
            ghost_reg <= in_ghost;
            last_reg  <= in_last;
            nv_reg    <= in_cur;
            wnum_reg  <= {w_diff[CW-1:0], FRAC_W'(0)};
            wden_reg  <= CW'(w_eff - 1'b1);
        end
        if (cmd.mul)
        begin
            pa_reg <= PW'(wt_s) * PW'(cur_reg);
            pb_reg <= PW'(wc_s) * PW'(ghost_reg);
        end
        if (cmd.blend)
        begin
            nv_reg <= t_sum[VALUE_WIDTH+FRAC_W-1:FRAC_W];
        end
        if (cmd.sq_chg || cmd.sq_val)
        begin
            sq_reg <= sq_sat(sq_op);
        end
        if (cmd.sqrt_init)
        begin
            rad_reg  <= div_q;
            srem_reg <= '0;
            root_reg <= '0;
        end
        else if (cmd.sqrt_step)
        begin
            rad_reg <= {rad_reg[SUM_W-3:0], 2'b00};
            if (srem_sh >= strial)
            begin
                srem_reg <= srem_sh - strial;
                root_reg <= {root_reg[NORM_W-2:0], 1'b1};
            end
            else
            begin
                srem_reg <= srem_sh;
                root_reg <= {root_reg[NORM_W-2:0], 1'b0};
            end
        end
    end

    assign value_zero = (value_sum_reg == '0);
    assign norm_ovf   = (SUM_W'(change_sum_reg[SUM_W-1:32]) >= value_sum_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            change_sum_reg <= '0;
            value_sum_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.sq_val)
            begin
                change_sum_reg <= sat_add(change_sum_reg, sq_reg);
            end
            if (cmd.accum)
            begin
                value_sum_reg <= sat_add(value_sum_reg, sq_reg);
            end
            if (cmd.load_out && last_reg)
            begin
                change_sum_reg <= '0;
                value_sum_reg  <= '0;
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            onv_reg   <= nv_reg;
            olast_reg <= last_reg;
            ozd_reg   <= en_reg && last_reg && value_zero;
            if (en_reg && last_reg)
            begin
                onorm_reg <= (value_zero || norm_ovf) ? '1 : root_reg;
            end
            else
            begin
                onorm_reg <= '0;
            end
        end
    end

    assign sts.enable     = en_reg;
    assign sts.last       = last_reg;
    assign sts.div_busy   = div_busy;
    assign sts.value_zero = value_zero;
    assign sts.norm_ovf   = norm_ovf;
    assign sts.out_free   = !out_valid_reg || out_ready;

    assign out_valid       = out_valid_reg;
    assign out_new_value   = onv_reg;
    assign out_norm_valid  = olast_reg;
    assign out_rel_norm    = onorm_reg;
    assign out_zero_divide = ozd_reg;

    `OBRN_ASSERT_NEXT(a_div_runs, clk, rst_n, div_start, div_busy)
    `OBRN_ASSERT_IMPL(a_col_range, clk, rst_n, 1'b1, WCMP'(col_reg) < WCMP'(OVERLAP_MAX))
    `OBRN_ASSERT_NEXT(a_sums_cleared, clk, rst_n, cmd.load_out && last_reg,
                      change_sum_reg == '0 && value_sum_reg == '0)
    `OBRN_ASSERT_IMPL(a_zdiv_norm, clk, rst_n, out_valid_reg && ozd_reg,
                      onorm_reg == '1 && olast_reg)

endmodule

/* hw/rtl/obrn_ctrl.sv */
// Controller state machine sequencing the datapath for one word at a time.
module obrn_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  obrn_pkg::sts_t sts,
    output obrn_pkg::cmd_t cmd
);
    import obrn_pkg::*;

    state_t                state_reg, state_next;
    logic [SQRT_CNT_W-1:0] cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = sts.enable ? S_WDIV_GO : S_DONE;
                end
            end
            S_WDIV_GO:
            begin
                cmd.wdiv_start = 1'b1;
                state_next     = S_WDIV_WAIT;
            end
            S_WDIV_WAIT:
            begin
                if (!sts.div_busy)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_BLEND;
            end
            S_BLEND:
            begin
                cmd.blend  = 1'b1;
                state_next = S_SQ_CHG;
            end
            S_SQ_CHG:
            begin
                cmd.sq_chg = 1'b1;
                state_next = S_SQ_VAL;
            end
            S_SQ_VAL:
            begin
                cmd.sq_val = 1'b1;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                cmd.accum  = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (sts.last && !sts.value_zero && !sts.norm_ovf)
                begin
                    state_next = S_NDIV_GO;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_NDIV_GO:
            begin
                cmd.ndiv_start = 1'b1;
                state_next     = S_NDIV_WAIT;
            end
            S_NDIV_WAIT:
            begin
                if (!sts.div_busy)
                begin
                    cmd.sqrt_init = 1'b1;
                    cnt_next      = '0;
                    state_next    = S_SQRT;
                end
            end
            S_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                cnt_next      = cnt_reg + 1'b1;
                if (cnt_reg == SQRT_CNT_W'(SQRT_STEPS - 1))
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

/* hw/rtl/overlap_blend_rel_norm_unit.sv */
// A word is accepted only in the idle state. With smoothing on, the controller then runs the weight
// division (one quotient bit a cycle), the two products, the blend, the two squares and the sums.
// A last word with a nonzero value sum and no norm overflow adds norm division and square root.
// With smoothing disabled a captured word goes straight to the done state; in both cases the result
// register is loaded once it is free. One word is in flight: none is taken before that load.
// Reset (rst_n low, asynchronous) clears column and sums and sets width 2, smoothing on.
module overlap_blend_rel_norm_unit #(
    parameter int OVERLAP_MAX = obrn_pkg::OVERLAP_MAX_DEF,
    parameter int VALUE_WIDTH = obrn_pkg::VALUE_WIDTH_DEF
) (
    input logic         clk,
    input logic         rst_n,
    obrn_in_if.sink     in_ch,
    obrn_out_if.source  out_ch,
    obrn_cfg_if.sink    cfg_ch
);
    import obrn_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // Configuration writes are taken unchecked; the user must write only while the unit is idle.
    assign cfg_ch.ready = 1'b1;

    // The controller owns the input handshake and walks the datapath through the weight division,
    // blend, squaring, accumulation and, at region end, the norm, when smoothing is enabled.
    obrn_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // The datapath holds the configuration, the running sums and the result word.
    obrn_dp #(
        .OVERLAP_MAX (OVERLAP_MAX),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_ch.valid),
        .cfg_index       (cfg_ch.index),
        .cfg_data        (cfg_ch.data),
        .in_cur          (in_ch.sub_value),
        .in_ghost        (in_ch.nbr_value),
        .in_last         (in_ch.last_element),
        .cmd             (cmd),
        .sts             (sts),
        .out_valid       (out_ch.valid),
        .out_ready       (out_ch.ready),
        .out_new_value   (out_ch.blend_value),
        .out_norm_valid  (out_ch.norm_valid),
        .out_rel_norm    (out_ch.rel_norm),
        .out_zero_divide (out_ch.zero_divide)
    );

endmodule

/* tb/sv/overlap_blend_rel_norm_unit_tb.sv */
// Testbench for the overlap blend and relative norm unit: directed and random traffic checked against a predictor.
`timescale 1ns / 1ps

module overlap_blend_rel_norm_unit_tb;
    import obrn_pkg::*;

    // One input word as the driver sends it.
    typedef struct {
        logic [31:0] cur;
        logic [31:0] ghost;
        logic        last;
    } elem_t;

    // One result word as the block should return it.
    typedef struct {
        logic [31:0] blend_value;
        logic        norm_valid;
        logic [31:0] rel_norm;
        logic        zero_divide;
    } blend_t;

    logic clk;
    logic rst_n;

    obrn_in_if  in_ch ();
    obrn_out_if out_ch ();
    obrn_cfg_if cfg_ch ();

    overlap_blend_rel_norm_unit DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source),
        .cfg_ch (cfg_ch.sink)
    );

    // Predictor state. It follows the block's registers and sums.
    int unsigned      pred_width;
    bit               pred_smooth;
    int unsigned      pred_col;
    logic [63:0]      pred_chg_sum;
    logic [63:0]      pred_val_sum;

    elem_t  pending_words[$];
    blend_t expected_words[$];
    int     error_count;
    bit     hold_sender;

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // Saturating square of a signed change or value.
    function automatic logic [63:0] sq_sat(longint d);
        logic [63:0] m;
        m = (d < 0) ? 64'(-d) : 64'(d);
        if (m >= 64'h1_0000_0000)
            return '1;
        return m * m;
    endfunction

    function automatic logic [63:0] add_sat(logic [63:0] a, logic [63:0] b);
        logic [64:0] r;
        r = {1'b0, a} + {1'b0, b};
        return r[64] ? '1 : r[63:0];
    endfunction

    // Integer square root by the classic bit-pair method.
    function automatic logic [31:0] root64(logic [63:0] x);
        logic [63:0] res;
        logic [63:0] bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > x)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (x >= res + bitv)
            begin
                x = x - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res[31:0];
    endfunction

    // Relative norm: sqrt of (change << 32) / value, saturating when the quotient overflows.
    function automatic logic [31:0] norm_of(logic [63:0] chg, logic [63:0] val);
        logic [127:0] q;
        if ((chg >> 32) >= val)
            return 32'hFFFF_FFFF;
        q = {chg, 32'd0} / {64'd0, val};
        return root64(q[63:0]);
    endfunction

    // Works out the result of one word and advances the predictor state.
    function automatic blend_t blend_word(elem_t e);
        blend_t      r;
        int unsigned w;
        longint      cur;
        longint      ghost;
        longint      wt;
        longint      t;
        longint      nv;
        cur = longint'($signed(e.cur));
        ghost = longint'($signed(e.ghost));
        nv = cur;
        w = pred_width;
        r.rel_norm = 0;
        r.zero_divide = 0;
        if (w < 2)
            w = 2;
        if (w > OVERLAP_MAX_DEF)
            w = OVERLAP_MAX_DEF;
        if (pred_col >= w)
            pred_col = 0;
        if (pred_smooth)
        begin
            wt = ((longint'(w - 1 - pred_col)) << 16) / longint'(w - 1);
            t = wt * cur + (65536 - wt) * ghost + 32768;
            nv = (t >= 0) ? (t >>> 16) : -((-t + 65535) >>> 16);
            pred_chg_sum = add_sat(pred_chg_sum, sq_sat(nv - cur));
            pred_val_sum = add_sat(pred_val_sum, sq_sat(nv));
            if (e.last)
            begin
                if (pred_val_sum == 0)
                begin
                    r.zero_divide = 1;
                    r.rel_norm = 32'hFFFF_FFFF;
                end
                else
                    r.rel_norm = norm_of(pred_chg_sum, pred_val_sum);
            end
        end
        pred_col = (pred_col + 1 >= w) ? 0 : pred_col + 1;
        if (e.last)
        begin
            pred_col = 0;
            pred_chg_sum = 0;
            pred_val_sum = 0;
        end
        r.blend_value = nv[31:0];
        r.norm_valid = e.last;
        return r;
    endfunction

    // Random gap length: mostly zero or short, now and then long.
    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50)
            return 0;
        if (p < 95)
            return $urandom_range(1, 4);
        return $urandom_range(10, 60);
    endfunction

    // Driver. It feeds words from the pending queue and predicts each one on acceptance.
    int send_gap;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            in_ch.sub_value <= '0;
            in_ch.nbr_value <= '0;
            in_ch.last_element <= 1'b0;
            send_gap <= 0;
        end
        else
        begin
            automatic bit busy = in_ch.valid;
            if (in_ch.valid && in_ch.ready)
            begin
                expected_words.push_back(blend_word('{in_ch.sub_value,
                    in_ch.nbr_value, in_ch.last_element}));
                busy = 1'b0;
            end
            if (!busy)
            begin
                if (send_gap > 0 || hold_sender || pending_words.size() == 0)
                begin
                    in_ch.valid <= 1'b0;
                    if (send_gap > 0)
                        send_gap <= send_gap - 1;
                end
                else
                begin
                    automatic elem_t e = pending_words.pop_front();
                    in_ch.valid <= 1'b1;
                    in_ch.sub_value <= e.cur;
                    in_ch.nbr_value <= e.ghost;
                    in_ch.last_element <= e.last;
                    send_gap <= gap_len();
                end
            end
        end
    end

    // Monitor. Results are compared field by field with the oldest expected word.
    int stall_len;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            stall_len <= 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_words.size() == 0)
                begin
                    $display("%0t: unexpected word blend_value=%h", $time, out_ch.blend_value);
                    error_count++;
                end
                else
                begin
                    automatic blend_t x = expected_words.pop_front();
                    if (x.blend_value !== out_ch.blend_value
                        || x.norm_valid !== out_ch.norm_valid
                        || x.rel_norm !== out_ch.rel_norm
                        || x.zero_divide !== out_ch.zero_divide)
                    begin
                        $display("%0t: mismatch expected nv=%h last=%b norm=%h zd=%b",
                            $time, x.blend_value, x.norm_valid, x.rel_norm, x.zero_divide);
                        $display("%0t:          actual   nv=%h last=%b norm=%h zd=%b",
                            $time, out_ch.blend_value, out_ch.norm_valid, out_ch.rel_norm,
                            out_ch.zero_divide);
                        error_count++;
                    end
                end
            end
            if (stall_len > 0)
            begin
                out_ch.ready <= 1'b0;
                stall_len <= stall_len - 1;
            end
            else
            begin
                out_ch.ready <= 1'b1;
                stall_len <= gap_len();
            end
        end
    end

    // Register write through the configuration channel; the predictor follows on acceptance.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= val;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        if (idx == REG_OVERLAP_WIDTH)
            pred_width = 32'(val);
        else if (idx == REG_SMOOTHING_ENABLE)
            pred_smooth = val[0];
    endtask

    // Waits until every queued word has been sent and answered, then lets the
    // block settle for longer than its slowest word before any register write.
    task automatic drain();
        while (pending_words.size() != 0 || in_ch.valid || expected_words.size() != 0)
            @(posedge clk);
        repeat (250) @(posedge clk);
    endtask

    // Random 32-bit value, biased toward extremes and small magnitudes now and then.
    function automatic logic [31:0] rand_val();
        int p;
        p = $urandom_range(0, 9);
        if (p == 0)
            return 32'h7FFF_FFFF;
        if (p == 1)
            return 32'h8000_0000;
        if (p == 2)
            return 32'($signed($urandom_range(0, 2000)) - 1000);
        return $urandom;
    endfunction

    // Queues n words of a region, the final one marked last, or, if broken, random marks and one more last word.
    task automatic queue_region(int n, bit broken);
        for (int i = 0; i < n; i++)
            pending_words.push_back('{rand_val(), rand_val(),
                broken ? 1'($urandom_range(0, 9) == 0) : (i == n - 1)});
        if (broken)
            pending_words.push_back('{rand_val(), rand_val(), 1'b1});
    endtask

    initial
    begin
        int sent;
        int w;
        int rows;
        error_count = 0;
        hold_sender = 0;
        pred_width = 32'(OW_RESET);
        pred_smooth = EN_RESET;
        pred_col = 0;
        pred_chg_sum = 0;
        pred_val_sum = 0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part at reset settings: field extremes and an all-zero region,
        // which has a zero sum of new values and so must flag a zero divide.
        pending_words.push_back('{32'h0, 32'h0, 1'b0});
        pending_words.push_back('{32'h0, 32'h0, 1'b1});
        pending_words.push_back('{32'h7FFF_FFFF, 32'h8000_0000, 1'b0});
        pending_words.push_back('{32'h8000_0000, 32'h7FFF_FFFF, 1'b1});
        pending_words.push_back('{32'h8000_0000, 32'h8000_0000, 1'b0});
        pending_words.push_back('{32'hFFFF_FFFF, 32'h0001_0000, 1'b1});
        // Words whose new values equal their inputs give a zero change sum and so a zero norm.
        pending_words.push_back('{32'h7FFF_FFFF, 32'h0, 1'b0});
        pending_words.push_back('{32'h0, 32'h0, 1'b1});
        pending_words.push_back('{32'h0001_0000, 32'h0002_0000, 1'b1});
        drain();

        // Width written below its minimum acts as two; smoothing off passes words.
        write_reg(REG_OVERLAP_WIDTH, 9'd0);
        write_reg(REG_SMOOTHING_ENABLE, 9'd0);
        pending_words.push_back('{32'h1234_5678, 32'h8765_4321, 1'b0});
        pending_words.push_back('{32'h8000_0000, 32'h7FFF_FFFF, 1'b1});
        drain();
        write_reg(REG_SMOOTHING_ENABLE, 9'd1);
        write_reg(REG_OVERLAP_WIDTH, 9'd511);
        queue_region(4, 0);
        drain();

        // Width changed mid-row: the column must restart once it lies beyond the width.
        write_reg(REG_OVERLAP_WIDTH, 9'd8);
        for (int i = 0; i < 6; i++)
            pending_words.push_back('{rand_val(), rand_val(), 1'b0});
        drain();
        write_reg(REG_OVERLAP_WIDTH, 9'd3);
        queue_region(4, 0);
        drain();

        // Random phases over several widths, both smoothing settings.
        sent = 0;
        while (sent < 1000)
        begin
            case ($urandom_range(0, 5))
                0: w = 2;
                1: w = 256;
                2: w = $urandom_range(257, 511);
                default: w = $urandom_range(2, 16);
            endcase
            write_reg(REG_OVERLAP_WIDTH, 9'(w));
            write_reg(REG_SMOOTHING_ENABLE, 9'($urandom_range(0, 4) != 0));
            // Wide rows get a single region so one phase stays short.
            for (int r = 0; r < ((w > 16) ? 1 : 6); r++)
            begin
                rows = (w > 16) ? 1 : $urandom_range(1, 3);
                if ($urandom_range(0, 7) == 0)
                    queue_region($urandom_range(1, 12), 1);
                else
                    queue_region(rows * ((w > 256) ? 256 : w), 0);
            end
            sent += pending_words.size();
            // Once in a while the sender holds until all results are back.
            if ($urandom_range(0, 3) == 0)
            begin
                hold_sender = 1;
                while (expected_words.size() != 0 || in_ch.valid)
                    @(posedge clk);
                hold_sender = 0;
            end
            drain();
        end

        if (error_count == 0)
            $display("overlap_blend_rel_norm_unit verification clean");
        else
            $display("overlap_blend_rel_norm_unit verification failed");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #20ms;
        $display("overlap_blend_rel_norm_unit verification failed");
        $finish;
    end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/obrn_pkg.sv
hw/rtl/obrn_if.sv
hw/rtl/obrn_div.sv
hw/rtl/obrn_dp.sv
hw/rtl/obrn_ctrl.sv
hw/rtl/overlap_blend_rel_norm_unit.sv
tb/sv/overlap_blend_rel_norm_unit_tb.sv
